>>> hw/rtl/wnpd_pkg.sv
// Shared types, codes and constants for the wave table NCO with phase distortion.
// No dependencies; every RTL file of the block imports this package.
`default_nettype none

package wnpd_pkg;

    localparam int TABLE_SIZE_DEF = 128;
    localparam int FRAC_W         = 16;
    localparam int SAMPLE_W       = 16;
    localparam int PHASE_W        = 32;
    localparam int CNT_W          = 7;
    localparam int BLEN_W         = 8;
    localparam int POINT_W        = 7;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;

    localparam logic signed [SAMPLE_W-1:0] DIFF_LIMIT_POS = 16'sd2000;
    localparam logic signed [SAMPLE_W-1:0] DIFF_LIMIT_NEG = -16'sd2000;
    localparam logic [BLEN_W-1:0]          BLOCK_MAX      = 8'd128;
    localparam logic [BLEN_W-1:0]          BLOCK_MIN      = 8'd1;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_TABLE  = 2'd1;
    localparam logic [1:0] ACT_STEP   = 2'd2;
    localparam logic [1:0] ACT_PHASE  = 2'd3;

    localparam logic [1:0] REG_DIST_ENABLE = 2'd0;
    localparam logic [1:0] REG_DIST_POINT  = 2'd1;
    localparam logic [1:0] REG_BLOCK_LEN   = 2'd2;

    typedef struct packed {
        logic [1:0]          action;
        logic [6:0]          table_index;
        logic [SAMPLE_W-1:0] table_value;
        logic [PHASE_W-1:0]  load_value;
    } in_word_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                block_end;
    } out_word_t;

    typedef struct packed {
        logic               distortion_enable;
        logic [POINT_W-1:0] distortion_point;
        logic [BLEN_W-1:0]  block_length;
    } cfg_t;

    typedef struct packed {
        logic [FRAC_W-1:0] frac;
        logic              block_end;
    } samp_info_t;

endpackage

`default_nettype wire

>>> hw/rtl/wnpd_regs.sv
// APB-style configuration registers: distortion enable, distortion point, block length.
// Depends on wnpd_pkg.
`default_nettype none

module wnpd_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [wnpd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [wnpd_pkg::DATA_W-1:0] pwdata,
    output logic      [wnpd_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output wnpd_pkg::cfg_t                   cfg
);
    import wnpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_DIST_ENABLE: cfg_next.distortion_enable = pwdata[0];
                REG_DIST_POINT:  cfg_next.distortion_point  = pwdata[POINT_W-1:0];
                REG_BLOCK_LEN:   cfg_next.block_length      = pwdata[BLEN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.distortion_enable <= 1'b0;
            cfg_reg.distortion_point  <= '0;
            cfg_reg.block_length      <= BLOCK_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DIST_ENABLE: prdata = DATA_W'(cfg_reg.distortion_enable);
            REG_DIST_POINT:  prdata = DATA_W'(cfg_reg.distortion_point);
            REG_BLOCK_LEN:   prdata = DATA_W'(cfg_reg.block_length);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/wnpd_phase.sv
// Phase accumulator, step with distortion reversal, and block sample counter.
// Produces table read indexes and fraction for each sample word. Depends on wnpd_pkg.
`default_nettype none

module wnpd_phase #(
    parameter int TABLE_SIZE = wnpd_pkg::TABLE_SIZE_DEF,
    localparam int IDX_W     = $clog2(TABLE_SIZE)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_fire,
    input  wire wnpd_pkg::in_word_t in_word,
    input  wire wnpd_pkg::cfg_t     cfg,
    output logic [IDX_W-1:0]        rd_idx,
    output logic [IDX_W-1:0]        rd_idx_next,
    output wnpd_pkg::samp_info_t    info
);
    import wnpd_pkg::*;

    localparam int          CMP_W  = (IDX_W > POINT_W) ? IDX_W : POINT_W;
    localparam logic [IDX_W:0] TS_EXT = (IDX_W+1)'(TABLE_SIZE);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W-1:0] step_reg, step_next;
    logic [PHASE_W-1:0] offset_reg, offset_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [IDX_W:0]     raw_ext;
    logic [IDX_W:0]     idx_ext;
    logic [IDX_W:0]     nxt_ext;
    logic               trigger;
    logic [PHASE_W-1:0] step_eff;
    logic [BLEN_W-1:0]  blen;
    logic [BLEN_W-1:0]  cnt_inc;
    logic               blk_end;
    logic               samp_fire;

    assign samp_fire = in_fire && (in_word.action == ACT_SAMPLE);

    always_comb
    begin
        raw_ext = {1'b0, phase_reg[PHASE_W-1 -: IDX_W]};
        idx_ext = (raw_ext >= TS_EXT) ? raw_ext - TS_EXT : raw_ext;
        nxt_ext = idx_ext + 1'b1;
        if (nxt_ext == TS_EXT)
            nxt_ext = '0;
    end

    assign rd_idx      = idx_ext[IDX_W-1:0];
    assign rd_idx_next = nxt_ext[IDX_W-1:0];

    assign trigger  = cfg.distortion_enable && (rd_idx != '0)
                   && (CMP_W'(rd_idx) == CMP_W'(cfg.distortion_point));
    assign step_eff = trigger ? step_reg - {step_reg[PHASE_W-2:0], 1'b0} : step_reg;

    always_comb
    begin
        priority if (cfg.block_length == '0)
            blen = BLOCK_MIN;
        else if (cfg.block_length > BLOCK_MAX)
            blen = BLOCK_MAX;
        else
            blen = cfg.block_length;
    end

    assign cnt_inc = BLEN_W'(cnt_reg) + 1'b1;
    assign blk_end = (cnt_inc >= blen);

    assign info.frac      = phase_reg[PHASE_W-1-IDX_W -: FRAC_W];
    assign info.block_end = blk_end;

    always_comb
    begin
        phase_next  = phase_reg;
        step_next   = step_reg;
        offset_next = offset_reg;
        cnt_next    = cnt_reg;
        if (in_fire)
        begin
            unique case (in_word.action)
                ACT_SAMPLE:
                begin
                    if (trigger)
                        offset_next = {step_reg[PHASE_W-2:0], 1'b0};
                    step_next  = step_eff;
                    phase_next = phase_reg + step_eff;
                    cnt_next   = blk_end ? '0 : cnt_inc[CNT_W-1:0];
                end
                ACT_STEP:  step_next  = in_word.load_value;
                ACT_PHASE: phase_next = in_word.load_value;
                default:   phase_next = phase_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            step_reg   <= '0;
            offset_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            offset_reg <= offset_next;
            cnt_reg    <= cnt_next;
        end
    end

    // distortion point reached: step reverses sign
    a_step_reverse: assert property (@(posedge clk) disable iff (!rst_n)
        samp_fire && trigger |=> step_reg == -$past(step_reg))
        else $error("step not reversed at distortion point");

    a_offset_doubled: assert property (@(posedge clk) disable iff (!rst_n)
        samp_fire && trigger |=> offset_reg == {$past(step_reg[PHASE_W-2:0]), 1'b0})
        else $error("distortion offset not twice the step");

    a_block_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        samp_fire && blk_end |=> cnt_reg == '0)
        else $error("sample counter not cleared at block end");

endmodule

`default_nettype wire

>>> hw/rtl/wnpd_table.sv
// Wave table memory: one write port, two registered read ports (entry and neighbor).
// Depends on wnpd_pkg for the sample width.
`default_nettype none

module wnpd_table #(
    parameter int TABLE_SIZE = wnpd_pkg::TABLE_SIZE_DEF,
    localparam int IDX_W     = $clog2(TABLE_SIZE)
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [6:0]                    wr_index,
    input  wire logic [wnpd_pkg::SAMPLE_W-1:0] wr_data,
    input  wire logic                          rd_en,
    input  wire logic [IDX_W-1:0]              rd_addr_a,
    input  wire logic [IDX_W-1:0]              rd_addr_b,
    output logic      [wnpd_pkg::SAMPLE_W-1:0] rd_data_a,
    output logic      [wnpd_pkg::SAMPLE_W-1:0] rd_data_b
);
    import wnpd_pkg::*;

    logic [SAMPLE_W-1:0] mem [TABLE_SIZE];
    logic [15:0]         wr_red;
    logic [IDX_W-1:0]    wr_addr;

    // write index reduced mod table size, restoring steps on a narrow value
    always_comb
    begin
        wr_red = 16'(wr_index);
        for (int k = 3; k >= 0; k--)
        begin
            if (wr_red >= (16'(TABLE_SIZE) << k))
                wr_red = wr_red - (16'(TABLE_SIZE) << k);
        end
    end

    assign wr_addr = wr_red[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/wnpd_interp.sv
// Linear interpolation between two table entries with a difference limit.
// Combinational; depends on wnpd_pkg.
`default_nettype none

module wnpd_interp (
    input  wire logic [wnpd_pkg::SAMPLE_W-1:0] entry_a,
    input  wire logic [wnpd_pkg::SAMPLE_W-1:0] entry_b,
    input  wire logic [wnpd_pkg::FRAC_W-1:0]   frac,
    output logic      [wnpd_pkg::SAMPLE_W-1:0] sample
);
    import wnpd_pkg::*;

    logic signed [SAMPLE_W-1:0]        diff;
    logic                              too_far;
    logic signed [SAMPLE_W+FRAC_W+1:0] prod;

    assign diff    = $signed(entry_b - entry_a);
    assign too_far = (diff > DIFF_LIMIT_POS) || (diff < DIFF_LIMIT_NEG);
    assign prod    = $signed({diff[SAMPLE_W-1], diff}) * $signed({1'b0, frac});
    assign sample  = too_far ? entry_a : entry_a + prod[SAMPLE_W+FRAC_W-1:FRAC_W];

endmodule

`default_nettype wire

>>> hw/rtl/wavetable_nco_phase_distortion_unit.sv
// Wave table NCO with phase distortion. A sample word passes the table read register, then
// the output register. Throughput: one word per cycle unless a stalled output holds the pipe;
// table, step and phase loads give no result.
// Reset: pipeline empty, phase, step, offset and counter zero, block length 128.
// Wave table contents are undefined after reset until written; no clearing pass.
`default_nettype none

module wavetable_nco_phase_distortion_unit #(
    parameter int TABLE_SIZE = wnpd_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire wnpd_pkg::in_word_t          in_word,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output wnpd_pkg::out_word_t              out_word,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [wnpd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [wnpd_pkg::DATA_W-1:0] pwdata,
    output logic      [wnpd_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import wnpd_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);

    cfg_t                cfg;
    samp_info_t          info;
    samp_info_t          s1_info_reg;
    logic                s1_valid_reg, s1_valid_next;
    logic                out_valid_reg, out_valid_next;
    out_word_t           out_word_reg;
    logic [IDX_W-1:0]    rd_idx, rd_idx_next;
    logic [SAMPLE_W-1:0] entry_a, entry_b;
    logic [SAMPLE_W-1:0] y;
    logic                in_fire, samp_fire, out_free, s1_move;

    assign out_free  = !out_valid_reg || out_ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign in_fire   = in_valid && in_ready;
    assign samp_fire = in_fire && (in_word.action == ACT_SAMPLE);

    wnpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wnpd_phase #(.TABLE_SIZE(TABLE_SIZE)) u_phase (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .in_word     (in_word),
        .cfg         (cfg),
        .rd_idx      (rd_idx),
        .rd_idx_next (rd_idx_next),
        .info        (info)
    );

    wnpd_table #(.TABLE_SIZE(TABLE_SIZE)) u_table (
        .clk       (clk),
        .wr_en     (in_fire && (in_word.action == ACT_TABLE)),
        .wr_index  (in_word.table_index),
        .wr_data   (in_word.table_value),
        .rd_en     (samp_fire),
        .rd_addr_a (rd_idx),
        .rd_addr_b (rd_idx_next),
        .rd_data_a (entry_a),
        .rd_data_b (entry_b)
    );

    wnpd_interp u_interp (
        .entry_a (entry_a),
        .entry_b (entry_b),
        .frac    (s1_info_reg.frac),
        .sample  (y)
    );

    always_comb
    begin
        priority if (samp_fire)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        priority if (s1_move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samp_fire)
            s1_info_reg <= info;
        if (s1_move)
        begin
            out_word_reg.sample    <= y;
            out_word_reg.block_end <= s1_info_reg.block_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a full pipeline");

    a_sample_enters: assert property (@(posedge clk) disable iff (!rst_n)
        samp_fire |=> s1_valid_reg)
        else $error("accepted sample word lost before read stage");

    a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("read stage advanced without filling output");

endmodule

`default_nettype wire

>>> test/wavetable_nco_phase_distortion_unit_tb.sv
// Self-checking bench for the wave table NCO with phase distortion: a table of directed
// words, then random words under three idle mixes, checked against an in-bench predictor.
// Depends on wnpd_pkg and wavetable_nco_phase_distortion_unit only.
`timescale 1ns / 100ps

module wavetable_nco_phase_distortion_unit_tb;
    import wnpd_pkg::*;

    typedef struct {
        in_word_t  word;
        bit        typed;
        out_word_t res;
    } dir_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    in_word_t            in_word   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_word_t           out_word;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // predictor state
    cfg_t                osc_cfg;
    logic [PHASE_W-1:0]  osc_phase;
    logic [PHASE_W-1:0]  osc_step;
    logic [PHASE_W-1:0]  osc_offset;
    logic [SAMPLE_W-1:0] wave_mem [128];
    logic [CNT_W-1:0]    block_count;

    out_word_t           expected_samples [$];
    out_word_t           sample_want;
    dir_row_t            dir_rows [$];

    int                  send_idle_pct   = 0;
    int                  recv_idle_pct   = 0;
    int                  hold_asks       = 0;
    int                  hold_seen       = 0;
    int                  hold_left       = 0;
    int                  mismatch_count  = 0;
    int                  words_sent      = 0;
    int                  results_checked = 0;
    int                  settings_done   = 0;

    int unsigned         en_list    [7] = '{0, 1, 1, 0, 1, 1, 1};
    int unsigned         point_list [7] = '{0, 127, 0, 5, 1, 64, 127};
    int unsigned         blen_list  [7] = '{128, 1, 0, 255, 2, 127, 128};

    wavetable_nco_phase_distortion_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d samples outstanding", expected_samples.size());
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 40)
            $display("%0t MISMATCH %s: got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic bit oscillator_step(input in_word_t w, output out_word_t res);
        logic [6:0]          idx;
        logic [FRAC_W-1:0]   frac;
        logic [SAMPLE_W-1:0] a;
        logic [SAMPLE_W-1:0] b;
        logic signed [15:0]  diff;
        logic signed [31:0]  prod;
        int                  len;
        res = '0;
        case (w.action)
            ACT_TABLE:
            begin
                wave_mem[w.table_index] = w.table_value;
                return 1'b0;
            end
            ACT_STEP:
            begin
                osc_step = w.load_value;
                return 1'b0;
            end
            ACT_PHASE:
            begin
                osc_phase = w.load_value;
                return 1'b0;
            end
            default: ;
        endcase
        idx  = osc_phase[31:25];
        frac = osc_phase[24:9];
        if (osc_cfg.distortion_enable && idx != 7'd0 && idx == osc_cfg.distortion_point)
        begin
            osc_offset = osc_step << 1;
            osc_step   = osc_step - osc_offset;
        end
        a    = wave_mem[idx];
        b    = wave_mem[idx + 7'd1];
        diff = b - a;
        if (diff > DIFF_LIMIT_POS || diff < DIFF_LIMIT_NEG)
            res.sample = a;
        else
        begin
            prod       = diff * $signed({16'd0, frac});
            res.sample = a + prod[31:16];
        end
        osc_phase = osc_phase + osc_step;
        len = int'(osc_cfg.block_length);
        if (len < BLOCK_MIN)
            len = BLOCK_MIN;
        if (len > BLOCK_MAX)
            len = BLOCK_MAX;
        if (int'(block_count) + 1 >= len)
        begin
            res.block_end = 1'b1;
            block_count   = '0;
        end
        else
            block_count = block_count + 1'b1;
        return 1'b1;
    endfunction

    // offers one word, waits for it to be taken, then records what it should produce
    task automatic send_word(input in_word_t w, input bit typed = 1'b0,
                             input out_word_t typed_res = '0);
        out_word_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_ready !== 1'b1);
        words_sent++;
        if (oscillator_step(w, res))
            expected_samples.push_back(typed ? typed_res : res);
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic apb_cycle(input bit wr, input logic [1:0] idx, input logic [31:0] data,
                             output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] got;
        case (idx)
            REG_DIST_ENABLE:
            begin
                mask = 32'h1;
                osc_cfg.distortion_enable = val[0];
            end
            REG_DIST_POINT:
            begin
                mask = 32'h7f;
                osc_cfg.distortion_point = val[POINT_W-1:0];
            end
            default:
            begin
                mask = 32'hff;
                osc_cfg.block_length = val[BLEN_W-1:0];
            end
        endcase
        apb_cycle(1'b1, idx, val, got);
        apb_cycle(1'b0, idx, 32'd0, got);
        if ((got & mask) !== (val & mask))
            report_mismatch("register readback", got, val & mask);
    endtask

    task automatic apply_setting(input int k);
        logic [31:0] en;
        logic [31:0] pt;
        logic [31:0] bl;
        if (k < 7)
        begin
            en = en_list[k];
            pt = point_list[k];
            bl = blen_list[k];
        end
        else
        begin
            en = $urandom_range(1);
            pt = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(127);
            bl = $urandom_range(1, 128);
        end
        quiesce();
        set_register(REG_DIST_ENABLE, en);
        set_register(REG_DIST_POINT, pt);
        set_register(REG_BLOCK_LEN, bl);
        settings_done++;
    endtask

    function automatic in_word_t random_word();
        in_word_t    w;
        int unsigned pick;
        w.table_index = 7'($urandom_range(127));
        w.table_value = 16'($urandom);
        w.load_value  = $urandom;
        pick = $urandom_range(99);
        if (pick < 70)
            w.action = ACT_SAMPLE;
        else if (pick < 82)
        begin
            w.action = ACT_TABLE;
            // half the writes stay near a neighbor so interpolation keeps firing
            if ($urandom_range(1) == 1)
                w.table_value = wave_mem[w.table_index - 7'd1]
                                + 16'($urandom_range(4200)) - 16'd2100;
        end
        else if (pick < 92)
        begin
            w.action = ACT_STEP;
            if ($urandom_range(3) != 0)
                w.load_value = $urandom_range(32'h0400_0000);
            if ($urandom_range(3) == 0)
                w.load_value = -w.load_value;
        end
        else
            w.action = ACT_PHASE;
        return w;
    endfunction

    function automatic void add_row(input logic [1:0] act, input logic [6:0] idx,
                                    input logic [15:0] val, input logic [31:0] load,
                                    input bit typed = 1'b0, input logic [15:0] smp = '0,
                                    input bit blk = 1'b0);
        dir_row_t r;
        r.word.action      = act;
        r.word.table_index = idx;
        r.word.table_value = val;
        r.word.load_value  = load;
        r.typed            = typed;
        r.res.sample       = smp;
        r.res.block_end    = blk;
        dir_rows.push_back(r);
    endfunction

    // output side: random stalls, plus a long hold when the stimulus asks for one
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_seen)
        begin
            hold_seen <= hold_asks;
            hold_left <= 300;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_samples.size() == 0)
                report_mismatch("sample word with none expected", 32'(out_word), 32'd0);
            else
            begin
                sample_want = expected_samples.pop_front();
                if (out_word.sample !== sample_want.sample)
                    report_mismatch("sample", 32'(out_word.sample), 32'(sample_want.sample));
                if (out_word.block_end !== sample_want.block_end)
                    report_mismatch("block_end", 32'(out_word.block_end),
                                    32'(sample_want.block_end));
                results_checked++;
            end
        end
    end

    initial
    begin
        logic [31:0] got;
        logic [15:0] walk;
        in_word_t    w;

        osc_cfg     = '{1'b0, 7'd0, BLOCK_MAX};
        osc_phase   = '0;
        osc_step    = '0;
        osc_offset  = '0;
        block_count = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_cycle(1'b0, REG_DIST_ENABLE, 32'd0, got);
        if (got[0] !== 1'b0)
            report_mismatch("distortion_enable after reset", got, 32'd0);
        apb_cycle(1'b0, REG_DIST_POINT, 32'd0, got);
        if (got[6:0] !== 7'd0)
            report_mismatch("distortion_point after reset", got, 32'd0);
        apb_cycle(1'b0, REG_BLOCK_LEN, 32'd0, got);
        if (got[7:0] !== BLOCK_MAX)
            report_mismatch("block_length after reset", got, 32'(BLOCK_MAX));

        send_idle_pct = 6;
        recv_idle_pct = 60;

        // the whole table is written before any sample reads it
        walk = 16'($urandom);
        for (int i = 0; i < 128; i++)
        begin
            walk = walk + 16'($urandom_range(3000)) - 16'd1500;
            w    = '{ACT_TABLE, 7'(i), walk, $urandom};
            send_word(w);
        end

        add_row(ACT_TABLE,  7'd0,   16'h1000, 32'd0);
        add_row(ACT_TABLE,  7'd1,   16'h1400, 32'd0);
        add_row(ACT_SAMPLE, 7'd0,   16'd0,    32'd0,         1'b1, 16'h1000);
        add_row(ACT_PHASE,  7'd0,   16'd0,    32'h0100_0000);
        add_row(ACT_SAMPLE, 7'd0,   16'd0,    32'd0,         1'b1, 16'h1200);
        add_row(ACT_TABLE,  7'd127, 16'hFFFF, 32'd0);
        add_row(ACT_PHASE,  7'd0,   16'd0,    32'hFE00_0000);
        add_row(ACT_SAMPLE, 7'd0,   16'd0,    32'd0,         1'b1, 16'hFFFF);
        add_row(ACT_TABLE,  7'd126, 16'h0000, 32'd0);
        add_row(ACT_PHASE,  7'd0,   16'd0,    32'hFDFF_FFFF);
        add_row(ACT_SAMPLE, 7'd0,   16'd0,    32'd0,         1'b1, 16'hFFFF);
        add_row(ACT_TABLE,  7'd2,   16'h1BD0, 32'd0);
        add_row(ACT_TABLE,  7'd3,   16'h23A1, 32'd0);
        add_row(ACT_STEP,   7'd0,   16'd0,    32'h0200_0000);
        add_row(ACT_PHASE,  7'd0,   16'd0,    32'h02FF_FE00);
        add_row(ACT_SAMPLE, 7'd0,   16'd0,    32'd0);
        add_row(ACT_SAMPLE, 7'd0,   16'd0,    32'd0);
        add_row(ACT_TABLE,  7'd4,   16'h1BD1, 32'd0);
        add_row(ACT_SAMPLE, 7'd0,   16'd0,    32'd0);
        add_row(ACT_TABLE,  7'd5,   16'h1400, 32'd0);
        add_row(ACT_SAMPLE, 7'd0,   16'd0,    32'd0);
        add_row(ACT_STEP,   7'd0,   16'd0,    32'hFFFF_FFFF);
        add_row(ACT_SAMPLE, 7'd0,   16'd0,    32'd0);
        add_row(ACT_PHASE,  7'd0,   16'd0,    32'hFFFF_FFFF);
        add_row(ACT_SAMPLE, 7'd0,   16'd0,    32'd0,         1'b1, 16'hFFFF);
        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);

        for (int mix = 0; mix < 3; mix++)
        begin
            send_idle_pct = (mix == 0) ? 6 : (mix == 1) ? 60 : 0;
            recv_idle_pct = (mix == 0) ? 60 : (mix == 1) ? 6 : 0;
            for (int chunk = 0; chunk < 5; chunk++)
            begin
                apply_setting(mix * 5 + chunk);
                if (mix == 2 && chunk == 0)
                begin
                    // long output hold while sample words keep coming
                    hold_asks++;
                    w.action = ACT_SAMPLE;
                    repeat (40)
                    begin
                        w.table_index = 7'($urandom_range(127));
                        w.table_value = 16'($urandom);
                        w.load_value  = $urandom;
                        send_word(w);
                    end
                end
                repeat (40)
                    send_word(random_word());
            end
        end

        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d words, checked %0d samples over %0d register settings,",
                 words_sent, results_checked, settings_done);
        $display("with three idle mixes, a long output hold and directed edge values.");
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
